// ----- hw/rtl/fltw_pkg.sv -----
// Shared types and constants for the four-level page table walker.
// Holds the queue item format, fault and command codes and the index helper.
// No dependencies.
package fltw_pkg;

    localparam int STORE_WORDS_DEF = 65536;

    localparam int VA_W     = 48;
    localparam int BASE_W   = 19;
    localparam int WIDX_W   = 16;
    localparam int DATA_W   = 64;
    localparam int OFF_W    = 33;
    localparam int BASE32_W = 32;
    localparam int IDX_W    = 9;
    localparam int PAGE_W   = 12;
    localparam int LEVELS   = 4;
    localparam int LVL_W    = 2;
    // Word index of a descriptor: a 29-bit table word offset plus a 9-bit index.
    localparam int WORD_W   = 30;

    localparam int Q_DEPTH  = 2;
    localparam int QPW      = $clog2(Q_DEPTH);
    localparam int QCW      = $clog2(Q_DEPTH + 1);

    localparam logic [DATA_W-1:0] DESC_ADDR_MASK = 64'h0000_0000_FFFF_F000;
    localparam logic [DATA_W-1:0] PAGE_OFF_MASK  = 64'h0000_0000_0000_0FFF;

    localparam logic [LVL_W-1:0] LVL_FIRST = 2'd0;
    localparam logic [LVL_W-1:0] LVL_LAST  = 2'd3;

    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_RAM_BASE = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_RAM_SIZE = 1'd1;

    localparam logic [BASE32_W-1:0] RAM_BASE_RST = 32'h4000_0000;
    localparam logic [OFF_W-1:0]    RAM_SIZE_RST = 33'h0_0008_0000;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_XLATE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        FAULT_OK    = 2'd0,
        FAULT_RANGE = 2'd1,
        FAULT_STORE = 2'd2
    } t_fault;

    typedef struct packed {
        t_cmd              cmd;
        logic              wr_ok;   // write index lies inside the store
        logic [VA_W-1:0]   va;
        logic [BASE_W-1:0] base;
        logic [WIDX_W-1:0] widx;
        logic [DATA_W-1:0] wdata;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // Nine-bit table index of the given level, level 0 being the top table.
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LVL_W-1:0] lvl);
        logic [VA_W-1:0] sh;
        sh = va >> (IDX_W * (LEVELS - 1 - int'(lvl)) + PAGE_W);
        return sh[IDX_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/fltw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fltw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fltw_front.sv -----
// Front end of the walker: accepts command beats, classifies them and queues them.
// Depends on fltw_pkg.
module fltw_front import fltw_pkg::*; #(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cmd,
    input  logic [VA_W-1:0]   i_virt_addr,
    input  logic [BASE_W-1:0] i_table_base,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [DATA_W-1:0] i_word_data,
    output logic              o_busy,
    output t_head             o_head,
    input  logic              i_pop
);

    localparam logic [31:0] WORDS_LIM = 32'(STORE_WORDS);

    t_item            r_q [Q_DEPTH];
    logic [QPW-1:0]   r_wptr, n_wptr;
    logic [QPW-1:0]   r_rptr, n_rptr;
    logic [QCW-1:0]   r_count, n_count;
    t_item            new_item;
    logic             push;

    assign o_busy = (r_count == QCW'(Q_DEPTH));
    assign push   = i_start && !o_busy;

    always_comb begin
        new_item.cmd   = t_cmd'(i_cmd);
        new_item.wr_ok = (32'(i_word_index) < WORDS_LIM);
        new_item.va    = i_virt_addr;
        new_item.base  = i_table_base;
        new_item.widx  = i_word_index;
        new_item.wdata = i_word_data;
    end

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QPW'(Q_DEPTH - 1)) ? '0 : r_wptr + QPW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPW'(Q_DEPTH - 1)) ? '0 : r_rptr + QPW'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= new_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rptr];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(Q_DEPTH))
        else $error("queue count exceeds its depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("back end took a beat from an empty queue");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_count == $past(r_count) + QCW'(1)))
        else $error("accepted beat not counted into the queue");
`endif

endmodule

// ----- hw/rtl/fltw_back.sv -----
// Back end of the walker: executes store writes and four-level translations.
// Depends on fltw_pkg; drives the store RAM held at the top level.
module fltw_back import fltw_pkg::*; #(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    localparam int AW = $clog2(STORE_WORDS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_head               i_head,
    output logic                o_pop,
    input  logic [BASE32_W-1:0] i_ram_base,
    input  logic [OFF_W-1:0]    i_ram_size,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic [DATA_W-1:0]   o_ram_wdata,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_raddr,
    input  logic [DATA_W-1:0]   i_ram_rdata,
    output logic                o_done,
    output logic [OFF_W-1:0]    o_xlat_off,
    output logic [1:0]          o_fault
);

    localparam logic [31:0] WORDS_LIM = 32'(STORE_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [VA_W-1:0]    r_va, n_va;
    logic               r_oob, n_oob;
    logic               r_done, n_done;
    logic [OFF_W-1:0]   r_phys, n_phys;
    t_fault             r_fault, n_fault;

    logic [DATA_W-1:0]  desc_masked;
    logic [BASE32_W:0]  diff;
    logic [BASE32_W-1:0] off;
    logic [BASE32_W-1:0] page_bits;
    logic               last;
    logic               range_bad;
    logic               idle;
    logic [VA_W-1:0]    src_va;
    logic [LVL_W-1:0]   src_lvl;
    logic [WORD_W-1:0]  tbl_words;
    logic [WORD_W-1:0]  word;
    logic [31:0]        word32;
    logic [31:0]        widx32;
    logic               oob;

    // Descriptor to offset: borrow means the base lies above the address,
    // which is flagged out of range along with any offset above the size.
    assign desc_masked = i_ram_rdata & DESC_ADDR_MASK;
    assign diff        = {1'b0, desc_masked[BASE32_W-1:0]} - {1'b0, i_ram_base};
    assign last        = (r_lvl == LVL_LAST);
    assign page_bits   = 32'(r_va & VA_W'(PAGE_OFF_MASK));
    assign off         = diff[BASE32_W-1:0] | (last ? page_bits : '0);
    assign range_bad   = diff[BASE32_W] || ({1'b0, off} > i_ram_size);

    // Address of the next descriptor, from the queue head or the walk in flight.
    assign idle      = (r_state == ST_IDLE);
    assign src_va    = idle ? i_head.item.va : r_va;
    assign src_lvl   = idle ? LVL_FIRST : r_lvl + LVL_W'(1);
    assign tbl_words = idle ? WORD_W'(i_head.item.base[BASE_W-1:3])
                            : WORD_W'(off[BASE32_W-1:3]);
    assign word      = tbl_words + WORD_W'(level_index(src_va, src_lvl));
    assign word32    = 32'(word);
    assign oob       = (word32 >= WORDS_LIM);
    assign widx32    = 32'(i_head.item.widx);

    assign o_ram_raddr = word32[AW-1:0];
    assign o_ram_waddr = widx32[AW-1:0];
    assign o_ram_wdata = i_head.item.wdata;

    always_comb begin
        n_state  = r_state;
        n_lvl    = r_lvl;
        n_va     = r_va;
        n_oob    = r_oob;
        n_done   = 1'b0;
        n_phys   = r_phys;
        n_fault  = r_fault;
        o_pop    = 1'b0;
        o_ram_we = 1'b0;
        o_ram_re = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.item.cmd == CMD_WRITE) begin
                        o_ram_we = i_head.item.wr_ok;
                        n_done   = 1'b1;
                        n_phys   = '0;
                        n_fault  = FAULT_OK;
                    end else begin
                        o_ram_re = 1'b1;
                        n_oob    = oob;
                        n_lvl    = LVL_FIRST;
                        n_va     = i_head.item.va;
                        n_state  = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_oob) begin
                    n_done  = 1'b1;
                    n_phys  = '0;
                    n_fault = FAULT_STORE;
                    n_state = ST_IDLE;
                end else if (range_bad) begin
                    n_done  = 1'b1;
                    n_phys  = '0;
                    n_fault = FAULT_RANGE;
                    n_state = ST_IDLE;
                end else if (last) begin
                    n_done  = 1'b1;
                    n_phys  = {1'b0, off};
                    n_fault = FAULT_OK;
                    n_state = ST_IDLE;
                end else begin
                    o_ram_re = 1'b1;
                    n_oob    = oob;
                    n_lvl    = r_lvl + LVL_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lvl   <= LVL_FIRST;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va    <= n_va;
        r_oob   <= n_oob;
        r_phys  <= n_phys;
        r_fault <= n_fault;
    end

    assign o_done     = r_done;
    assign o_xlat_off = r_phys;
    assign o_fault    = r_fault;

`ifndef SYNTH
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_fault == FAULT_OK || r_phys == '0))
        else $error("faulted result carries a non-zero offset");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && r_lvl == LVL_LAST) |=> (r_state == ST_IDLE))
        else $error("walk continued past the last level");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_head.valid && r_state == ST_IDLE))
        else $error("beat taken while walking or with nothing queued");
`endif

endmodule

// ----- hw/rtl/four_level_page_table_walk.sv -----
// Top level of the four-level page table walker: configuration registers,
// descriptor store, front-end queue and walk engine. Depends on fltw_pkg.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------
//  command   | start in, busy out          | i_cmd, i_virt_addr, i_table_base,
//            |                             | i_word_index, i_word_data
//  result    | o_done strobe, one cycle    | o_xlat_off, o_fault
//  config    | i_cfg_we, no wait           | i_cfg_index, i_cfg_data
//
// A store write is done from the engine's idle state; a translation reads one
// descriptor per level from the single read port, then does the check.
// A two-beat queue lets commands be taken while the engine is walking; busy
// rises only when that queue is full. The result appears on the cycle after
// the engine finishes the beat. Reset is synchronous and clears control state;
// the store contents are not cleared.
module four_level_page_table_walk import fltw_pkg::*; #(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [VA_W-1:0]   i_virt_addr,
    input  logic [BASE_W-1:0] i_table_base,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [DATA_W-1:0] i_word_data,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [OFF_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [OFF_W-1:0]  o_xlat_off,
    output logic [1:0]        o_fault
);

    localparam int AW = $clog2(STORE_WORDS);

    logic [BASE32_W-1:0] r_ram_base;
    logic [OFF_W-1:0]    r_ram_size;

    t_head               head;
    logic                pop;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_base <= RAM_BASE_RST;
            r_ram_size <= RAM_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAM_BASE: r_ram_base <= i_cfg_data[BASE32_W-1:0];
                CFG_RAM_SIZE: r_ram_size <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fltw_front #(
        .STORE_WORDS (STORE_WORDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_virt_addr  (i_virt_addr),
        .i_table_base (i_table_base),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .o_busy       (busy),
        .o_head       (head),
        .i_pop        (pop)
    );

    fltw_back #(
        .STORE_WORDS (STORE_WORDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_ram_base    (r_ram_base),
        .i_ram_size    (r_ram_size),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_done        (o_done),
        .o_xlat_off    (o_xlat_off),
        .o_fault       (o_fault)
    );

    fltw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
